// ----- hw/rtl/ftb_pkg.sv -----
// Shared types and number format for the face tangent basis core.
package ftb_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = 30;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic        [VALUE_WIDTH-1:0] mag_type;

   typedef struct packed {
      value_type normal_x;
      value_type normal_y;
      value_type normal_z;
   } req_type;

   typedef struct packed {
      value_type tan1_x;
      value_type tan1_y;
      value_type tan1_z;
      value_type tan2_x;
      value_type tan2_y;
      value_type tan2_z;
      logic      degenerate;
   } rsp_type;

   // Which normal component chose the first tangent
   typedef enum logic [1:0] {
      PICK_X    = 2'd0,
      PICK_Y    = 2'd1,
      PICK_Z    = 2'd2,
      PICK_NONE = 2'd3
   } pick_type;

   // Per-stage control and normal data that travel beside the arithmetic
   typedef struct packed {
      logic     valid;
      pick_type pick;
      logic     neg_a;
      logic     neg_b;
      logic     neg_x;
      logic     neg_y;
      logic     neg_z;
      mag_type  mag_x;
      mag_type  mag_y;
      mag_type  mag_z;
   } side_type;

endpackage

// ----- hw/rtl/face_tangent_basis_core.sv -----
// Face tangent basis core: unit first tangent and cross-product second tangent per normal.
//
// One normal enters per clock; the pipeline keeps one item per clock as long as the
// result side takes them. The length of the pipeline comes from the 32-stage square root
// of the squared tangent length and the 31-stage restoring divider that scales each
// tangent component, each stage resolving one result bit. When the result register is
// full and stalled, the whole pipeline holds and req_stall rises.
// An all-zero normal returns zero tangents with degenerate set.
module face_tangent_basis_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ftb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ftb_pkg::rsp_type rsp_data
);

   localparam int W       = ftb_pkg::VALUE_WIDTH;
   localparam int F       = ftb_pkg::FRAC_BITS;
   localparam int NORM_W  = 31;
   localparam int EXMAX   = W - NORM_W;
   localparam int NR      = $clog2(EXMAX + 1);
   localparam int RAD_W   = 2 * NORM_W + 2;
   localparam int NL      = $clog2(NORM_W + 1);
   localparam int ROOT_W  = RAD_W / 2;
   localparam int REM_W   = ROOT_W + 2;
   localparam int R2_W    = REM_W + 2;
   localparam int M_W     = ROOT_W;
   localparam int QUO_W   = F + 1;
   localparam int CMP_W   = ((QUO_W > W) ? QUO_W : W) + 1;
   localparam int PROD_W  = 2 * W;
   localparam int SP_W    = PROD_W + 2;
   localparam int SH_W    = SP_W - F;

   localparam logic [CMP_W-1:0] LIM_POS = CMP_W'({(W-1){1'b1}});
   localparam logic [CMP_W-1:0] LIM_NEG = LIM_POS + CMP_W'(1);
   localparam logic signed [SP_W-1:0] HALF = SP_W'(1) << (F - 1);
   localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'({(W-1){1'b1}});
   localparam logic signed [SH_W-1:0] SAT_MIN = ~SAT_MAX;

   logic adv;

   // Pipeline registers
   ftb_pkg::side_type nr_side_ff [0:NR];
   ftb_pkg::mag_type  nr_a_ff    [0:NR];
   ftb_pkg::mag_type  nr_b_ff    [0:NR];

   ftb_pkg::side_type       sq_side_ff;
   logic [2*NORM_W-1:0]     sq_a_ff, sq_b_ff;
   logic [NORM_W-1:0]       sq_ma_ff, sq_mb_ff;

   ftb_pkg::side_type nl_side_ff [0:NL];
   logic [RAD_W-1:0]  nl_s_ff    [0:NL];
   logic [M_W-1:0]    nl_ma_ff   [0:NL];
   logic [M_W-1:0]    nl_mb_ff   [0:NL];

   ftb_pkg::side_type sr_side_ff [1:ROOT_W];
   logic [REM_W-1:0]  sr_rem_ff  [1:ROOT_W];
   logic [ROOT_W-1:0] sr_root_ff [1:ROOT_W];
   logic [RAD_W-1:0]  sr_rad_ff  [1:ROOT_W];
   logic [M_W-1:0]    sr_ma_ff   [1:ROOT_W];
   logic [M_W-1:0]    sr_mb_ff   [1:ROOT_W];

   ftb_pkg::side_type dv_side_ff [1:QUO_W];
   logic [ROOT_W-1:0] dv_len_ff  [1:QUO_W];
   logic [M_W-1:0]    dv_ra_ff   [1:QUO_W];
   logic [M_W-1:0]    dv_rb_ff   [1:QUO_W];
   logic [QUO_W-1:0]  dv_qa_ff   [1:QUO_W];
   logic [QUO_W-1:0]  dv_qb_ff   [1:QUO_W];

   ftb_pkg::side_type  en_side_ff;
   ftb_pkg::value_type en_ux_ff, en_uy_ff;
   ftb_pkg::mag_type   en_mx_ff, en_my_ff;

   ftb_pkg::side_type  mu_side_ff;
   ftb_pkg::value_type mu_ux_ff, mu_uy_ff;
   logic [PROD_W-1:0]  mu_zy_ff, mu_zx_ff, mu_xy_ff, mu_yx_ff;

   ftb_pkg::side_type        cb_side_ff;
   ftb_pkg::value_type       cb_ux_ff, cb_uy_ff;
   logic signed [SP_W-1:0]   cb_vx_ff, cb_vy_ff, cb_vz_ff;

   logic             rsp_valid_ff;
   ftb_pkg::rsp_type rsp_data_ff;

   // Advance everything unless a finished item is stuck in the output register
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- decode and pick
   ftb_pkg::mag_type  mx_in, my_in, mz_in, a_in, b_in;
   ftb_pkg::side_type s0_in;

   always_comb begin
      mx_in = req_data.normal_x[W-1] ? ftb_pkg::mag_type'(-req_data.normal_x)
                                     : ftb_pkg::mag_type'(req_data.normal_x);
      my_in = req_data.normal_y[W-1] ? ftb_pkg::mag_type'(-req_data.normal_y)
                                     : ftb_pkg::mag_type'(req_data.normal_y);
      mz_in = req_data.normal_z[W-1] ? ftb_pkg::mag_type'(-req_data.normal_z)
                                     : ftb_pkg::mag_type'(req_data.normal_z);
      s0_in.valid = req_valid;
      s0_in.neg_x = req_data.normal_x[W-1];
      s0_in.neg_y = req_data.normal_y[W-1];
      s0_in.neg_z = req_data.normal_z[W-1];
      s0_in.mag_x = mx_in;
      s0_in.mag_y = my_in;
      s0_in.mag_z = mz_in;
      priority if (mx_in != '0) begin
         s0_in.pick  = ftb_pkg::PICK_X;
         a_in        = my_in;
         s0_in.neg_a = req_data.normal_y[W-1];
         b_in        = mx_in;
         s0_in.neg_b = !req_data.normal_x[W-1];
      end else if (my_in != '0) begin
         s0_in.pick  = ftb_pkg::PICK_Y;
         a_in        = my_in;
         s0_in.neg_a = !req_data.normal_y[W-1];
         b_in        = '0;
         s0_in.neg_b = 1'b0;
      end else if (mz_in != '0) begin
         s0_in.pick  = ftb_pkg::PICK_Z;
         a_in        = '0;
         s0_in.neg_a = 1'b0;
         b_in        = mz_in;
         s0_in.neg_b = !req_data.normal_z[W-1];
      end else begin
         s0_in.pick  = ftb_pkg::PICK_NONE;
         a_in        = '0;
         s0_in.neg_a = 1'b0;
         b_in        = '0;
         s0_in.neg_b = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nr_side_ff[0].valid <= 1'b0;
      end else if (adv) begin
         nr_side_ff[0] <= s0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nr_a_ff[0] <= a_in;
         nr_b_ff[0] <= b_in;
      end
   end

   // ---------------------------------------------------------------- narrow to 31 bits
   for (genvar i = 1; i <= NR; i++) begin : g_nr
      localparam int D = 1 << (NR - i);
      logic do_shift;

      assign do_shift = |(nr_a_ff[i-1][W-1:NORM_W-1+D] | nr_b_ff[i-1][W-1:NORM_W-1+D]);

      always_ff @(posedge clock) begin
         if (reset) begin
            nr_side_ff[i].valid <= 1'b0;
         end else if (adv) begin
            nr_side_ff[i] <= nr_side_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            nr_a_ff[i] <= do_shift ? (nr_a_ff[i-1] >> D) : nr_a_ff[i-1];
            nr_b_ff[i] <= do_shift ? (nr_b_ff[i-1] >> D) : nr_b_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------- squares and sum
   logic [NORM_W-1:0]   a_nrm, b_nrm;
   logic [2*NORM_W-1:0] sq_a_in, sq_b_in;

   assign a_nrm   = nr_a_ff[NR][NORM_W-1:0];
   assign b_nrm   = nr_b_ff[NR][NORM_W-1:0];
   assign sq_a_in = (2*NORM_W)'(a_nrm) * (2*NORM_W)'(a_nrm);
   assign sq_b_in = (2*NORM_W)'(b_nrm) * (2*NORM_W)'(b_nrm);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_side_ff.valid    <= 1'b0;
         nl_side_ff[0].valid <= 1'b0;
      end else if (adv) begin
         sq_side_ff    <= nr_side_ff[NR];
         nl_side_ff[0] <= sq_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_a_ff     <= sq_a_in;
         sq_b_ff     <= sq_b_in;
         sq_ma_ff    <= a_nrm;
         sq_mb_ff    <= b_nrm;
         nl_s_ff[0]  <= RAD_W'(sq_a_ff) + RAD_W'(sq_b_ff);
         nl_ma_ff[0] <= M_W'(sq_ma_ff);
         nl_mb_ff[0] <= M_W'(sq_mb_ff);
      end
   end

   // ---------------------------------------------------------------- normalize sum by 4^k
   for (genvar i = 1; i <= NL; i++) begin : g_nl
      localparam int D = 1 << (NL - i);
      logic do_shift;

      assign do_shift = ~|nl_s_ff[i-1][RAD_W-1 -: 2*D];

      always_ff @(posedge clock) begin
         if (reset) begin
            nl_side_ff[i].valid <= 1'b0;
         end else if (adv) begin
            nl_side_ff[i] <= nl_side_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            nl_s_ff[i]  <= do_shift ? (nl_s_ff[i-1] << (2*D)) : nl_s_ff[i-1];
            nl_ma_ff[i] <= do_shift ? (nl_ma_ff[i-1] << D) : nl_ma_ff[i-1];
            nl_mb_ff[i] <= do_shift ? (nl_mb_ff[i-1] << D) : nl_mb_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------- square root, one bit a stage
   for (genvar i = 1; i <= ROOT_W; i++) begin : g_sqrt
      ftb_pkg::side_type side_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RAD_W-1:0]  rad_prev;
      logic [M_W-1:0]    ma_prev, mb_prev;
      logic [R2_W-1:0]   r2, trial;
      logic              ge;

      if (i == 1) begin : g_first
         assign side_prev = nl_side_ff[NL];
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = nl_s_ff[NL];
         assign ma_prev   = nl_ma_ff[NL];
         assign mb_prev   = nl_mb_ff[NL];
      end else begin : g_next
         assign side_prev = sr_side_ff[i-1];
         assign rem_prev  = sr_rem_ff[i-1];
         assign root_prev = sr_root_ff[i-1];
         assign rad_prev  = sr_rad_ff[i-1];
         assign ma_prev   = sr_ma_ff[i-1];
         assign mb_prev   = sr_mb_ff[i-1];
      end

      assign r2    = {rem_prev, rad_prev[RAD_W-1 -: 2]};
      assign trial = R2_W'({root_prev, 2'b01});
      assign ge    = r2 >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sr_side_ff[i].valid <= 1'b0;
         end else if (adv) begin
            sr_side_ff[i] <= side_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sr_rem_ff[i]  <= ge ? REM_W'(r2 - trial) : REM_W'(r2);
            sr_root_ff[i] <= {root_prev[ROOT_W-2:0], ge};
            sr_rad_ff[i]  <= rad_prev << 2;
            sr_ma_ff[i]   <= ma_prev;
            sr_mb_ff[i]   <= mb_prev;
         end
      end
   end

   // ---------------------------------------------------------------- divide by length, one bit a stage
   for (genvar i = 1; i <= QUO_W; i++) begin : g_div
      ftb_pkg::side_type side_prev;
      logic [ROOT_W-1:0] len_prev;
      logic [M_W:0]      ra2, rb2, len_ext;
      logic [QUO_W-1:0]  qa_prev, qb_prev;
      logic              ge_a, ge_b;

      if (i == 1) begin : g_first
         assign side_prev = sr_side_ff[ROOT_W];
         assign len_prev  = sr_root_ff[ROOT_W];
         assign ra2       = {1'b0, sr_ma_ff[ROOT_W]};
         assign rb2       = {1'b0, sr_mb_ff[ROOT_W]};
         assign qa_prev   = '0;
         assign qb_prev   = '0;
      end else begin : g_next
         assign side_prev = dv_side_ff[i-1];
         assign len_prev  = dv_len_ff[i-1];
         assign ra2       = {dv_ra_ff[i-1], 1'b0};
         assign rb2       = {dv_rb_ff[i-1], 1'b0};
         assign qa_prev   = dv_qa_ff[i-1];
         assign qb_prev   = dv_qb_ff[i-1];
      end

      assign len_ext = (M_W+1)'(len_prev);
      assign ge_a    = ra2 >= len_ext;
      assign ge_b    = rb2 >= len_ext;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_side_ff[i].valid <= 1'b0;
         end else if (adv) begin
            dv_side_ff[i] <= side_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_len_ff[i] <= len_prev;
            dv_ra_ff[i]  <= ge_a ? M_W'(ra2 - len_ext) : M_W'(ra2);
            dv_rb_ff[i]  <= ge_b ? M_W'(rb2 - len_ext) : M_W'(rb2);
            dv_qa_ff[i]  <= {qa_prev[QUO_W-2:0], ge_a};
            dv_qb_ff[i]  <= {qb_prev[QUO_W-2:0], ge_b};
         end
      end
   end

   // ---------------------------------------------------------------- saturate unit tangent
   ftb_pkg::side_type  dv_last;
   logic [CMP_W-1:0]   qa_ext, qb_ext, lim_a, lim_b, sat_a, sat_b;
   ftb_pkg::mag_type   mag_a, mag_b;
   ftb_pkg::value_type ux_in, uy_in;

   always_comb begin
      dv_last = dv_side_ff[QUO_W];
      qa_ext  = CMP_W'(dv_qa_ff[QUO_W]);
      qb_ext  = CMP_W'(dv_qb_ff[QUO_W]);
      lim_a   = dv_last.neg_a ? LIM_NEG : LIM_POS;
      lim_b   = dv_last.neg_b ? LIM_NEG : LIM_POS;
      sat_a   = (qa_ext > lim_a) ? lim_a : qa_ext;
      sat_b   = (qb_ext > lim_b) ? lim_b : qb_ext;
      // zero normal: drop whatever the divider made of a zero length
      if (dv_last.pick == ftb_pkg::PICK_NONE) begin
         sat_a = '0;
         sat_b = '0;
      end
      mag_a = W'(sat_a);
      mag_b = W'(sat_b);
      ux_in = dv_last.neg_a ? -$signed(mag_a) : $signed(mag_a);
      uy_in = dv_last.neg_b ? -$signed(mag_b) : $signed(mag_b);
   end

   // ---------------------------------------------------------------- cross product
   logic signed [SP_W-1:0] t_zy, t_zx, t_xy, t_yx;

   always_comb begin
      t_zy = $signed({2'b00, mu_zy_ff});
      t_zx = $signed({2'b00, mu_zx_ff});
      t_xy = $signed({2'b00, mu_xy_ff});
      t_yx = $signed({2'b00, mu_yx_ff});
      if (mu_side_ff.neg_z ^ mu_side_ff.neg_b) begin
         t_zy = -t_zy;
      end
      if (mu_side_ff.neg_z ^ mu_side_ff.neg_a) begin
         t_zx = -t_zx;
      end
      if (mu_side_ff.neg_x ^ mu_side_ff.neg_b) begin
         t_xy = -t_xy;
      end
      if (mu_side_ff.neg_y ^ mu_side_ff.neg_a) begin
         t_yx = -t_yx;
      end
   end

   function automatic ftb_pkg::value_type round_sat(input logic signed [SP_W-1:0] v);
      logic signed [SH_W-1:0] r;
      ftb_pkg::value_type     res;
      r = v[SP_W-1:F];
      priority if (r > SAT_MAX) begin
         res = SAT_MAX[W-1:0];
      end else if (r < SAT_MIN) begin
         res = SAT_MIN[W-1:0];
      end else begin
         res = r[W-1:0];
      end
      return res;
   endfunction

   ftb_pkg::rsp_type rsp_in;

   always_comb begin
      rsp_in.tan1_x     = cb_ux_ff;
      rsp_in.tan1_y     = cb_uy_ff;
      rsp_in.tan1_z     = '0;
      rsp_in.tan2_x     = round_sat(cb_vx_ff);
      rsp_in.tan2_y     = round_sat(cb_vy_ff);
      rsp_in.tan2_z     = round_sat(cb_vz_ff);
      rsp_in.degenerate = (cb_side_ff.pick == ftb_pkg::PICK_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_side_ff.valid <= 1'b0;
         mu_side_ff.valid <= 1'b0;
         cb_side_ff.valid <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else if (adv) begin
         en_side_ff   <= dv_last;
         mu_side_ff   <= en_side_ff;
         cb_side_ff   <= mu_side_ff;
         rsp_valid_ff <= cb_side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         en_ux_ff    <= ux_in;
         en_uy_ff    <= uy_in;
         en_mx_ff    <= mag_a;
         en_my_ff    <= mag_b;
         mu_ux_ff    <= en_ux_ff;
         mu_uy_ff    <= en_uy_ff;
         mu_zy_ff    <= PROD_W'(en_side_ff.mag_z) * PROD_W'(en_my_ff);
         mu_zx_ff    <= PROD_W'(en_side_ff.mag_z) * PROD_W'(en_mx_ff);
         mu_xy_ff    <= PROD_W'(en_side_ff.mag_x) * PROD_W'(en_my_ff);
         mu_yx_ff    <= PROD_W'(en_side_ff.mag_y) * PROD_W'(en_mx_ff);
         cb_ux_ff    <= mu_ux_ff;
         cb_uy_ff    <= mu_uy_ff;
         cb_vx_ff    <= HALF - t_zy;
         cb_vy_ff    <= HALF + t_zx;
         cb_vz_ff    <= HALF + t_xy - t_yx;
         rsp_data_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   a_sum_normalized: assert property (@(posedge clock) disable iff (reset)
      nl_side_ff[NL].valid && nl_side_ff[NL].pick != ftb_pkg::PICK_NONE
      |-> nl_s_ff[NL][RAD_W-1 -: 2] != 2'b00)
      else $error("normalized squared length below range");

   a_root_msb: assert property (@(posedge clock) disable iff (reset)
      sr_side_ff[ROOT_W].valid && sr_side_ff[ROOT_W].pick != ftb_pkg::PICK_NONE
      |-> sr_root_ff[ROOT_W][ROOT_W-1])
      else $error("tangent length lost its top bit");

   a_quo_unit: assert property (@(posedge clock) disable iff (reset)
      dv_side_ff[QUO_W].valid && dv_side_ff[QUO_W].pick != ftb_pkg::PICK_NONE
      |-> dv_qa_ff[QUO_W] <= (QUO_W'(1) << F) && dv_qb_ff[QUO_W] <= (QUO_W'(1) << F))
      else $error("scaled tangent component above one");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.degenerate
      |-> rsp_data_ff.tan1_x == '0 && rsp_data_ff.tan1_y == '0 &&
          rsp_data_ff.tan2_x == '0 && rsp_data_ff.tan2_y == '0 &&
          rsp_data_ff.tan2_z == '0)
      else $error("degenerate item with nonzero tangent");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the face tangent basis core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint UNIT_ONE  = 64'sd1 <<< ftb_pkg::FRAC_BITS;
   localparam longint VALUE_MAX = (64'sd1 <<< (ftb_pkg::VALUE_WIDTH - 1)) - 1;
   localparam longint VALUE_MIN = -(64'sd1 <<< (ftb_pkg::VALUE_WIDTH - 1));

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ftb_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ftb_pkg::rsp_type rsp_data;

   ftb_pkg::req_type normal_queue[$];
   ftb_pkg::rsp_type basis_queue[$];
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      error_count = 0;
   int      basis_checked = 0;
   int      degenerate_seen = 0;

   face_tangent_basis_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] root_floor(logic [63:0] s);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s = s - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // round((a*b - c*d) / 2^FRAC_BITS), saturated
   function automatic ftb_pkg::value_type cross_round(longint a, longint b,
                                                      longint c, longint d);
      logic signed [127:0] wa, wb, wc, wd, acc;
      wa = a; wb = b; wc = c; wd = d;
      acc = wa * wb - wc * wd + (128'sd1 <<< (ftb_pkg::FRAC_BITS - 1));
      acc = acc >>> ftb_pkg::FRAC_BITS;
      if (acc > VALUE_MAX) return ftb_pkg::value_type'(VALUE_MAX);
      if (acc < VALUE_MIN) return ftb_pkg::value_type'(VALUE_MIN);
      return ftb_pkg::value_type'(acc);
   endfunction

   function automatic ftb_pkg::rsp_type tangent_basis(ftb_pkg::req_type n);
      ftb_pkg::rsp_type r;
      longint nx, ny, nz, t[3], u[3];
      logic [63:0] m[3], s, len, q;
      int k;
      r = '0;
      nx = n.normal_x; ny = n.normal_y; nz = n.normal_z;
      if (nx != 0) begin
         t[0] = ny; t[1] = -nx; t[2] = 0;
      end else if (ny != 0) begin
         t[0] = -ny; t[1] = nx; t[2] = 0;
      end else if (nz != 0) begin
         t[0] = 0; t[1] = -nz; t[2] = ny;
      end else begin
         r.degenerate = 1'b1;
         return r;
      end
      for (int i = 0; i < 3; i++) m[i] = (t[i] < 0) ? -t[i] : t[i];
      while (m[0] >= 64'd1 << 31 || m[1] >= 64'd1 << 31 || m[2] >= 64'd1 << 31)
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      k = 0;
      while (s < 64'd1 << 62) begin
         s = s << 2;
         k++;
      end
      len = root_floor(s);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << k) << ftb_pkg::FRAC_BITS) / len;
         if (t[i] < 0) u[i] = (q > -VALUE_MIN) ? VALUE_MIN : -longint'(q);
         else u[i] = (q > VALUE_MAX) ? VALUE_MAX : longint'(q);
      end
      r.tan1_x = ftb_pkg::value_type'(u[0]);
      r.tan1_y = ftb_pkg::value_type'(u[1]);
      r.tan1_z = ftb_pkg::value_type'(u[2]);
      r.tan2_x = cross_round(ny, u[2], nz, u[1]);
      r.tan2_y = cross_round(nz, u[0], nx, u[2]);
      r.tan2_z = cross_round(nx, u[1], ny, u[0]);
      return r;
   endfunction

   function automatic ftb_pkg::value_type pick_component();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return ftb_pkg::value_type'(VALUE_MAX);
         2: return ftb_pkg::value_type'(VALUE_MIN);
         3: return ftb_pkg::value_type'(UNIT_ONE);
         4: return ftb_pkg::value_type'($signed($urandom_range(0, 200)) - 100);
         default: return ftb_pkg::value_type'($urandom);
      endcase
   endfunction

   task automatic queue_normal(longint x, longint y, longint z);
      ftb_pkg::req_type n;
      n.normal_x = ftb_pkg::value_type'(x);
      n.normal_y = ftb_pkg::value_type'(y);
      n.normal_z = ftb_pkg::value_type'(z);
      normal_queue.push_back(n);
   endtask

   task automatic queue_random(int count);
      ftb_pkg::req_type n;
      repeat (count) begin
         n.normal_x = pick_component();
         n.normal_y = pick_component();
         n.normal_z = pick_component();
         // bias toward leading zeros so the y and z picks are exercised
         case ($urandom_range(0, 3))
            0: n.normal_x = '0;
            1: begin n.normal_x = '0; n.normal_y = '0; end
            default: ;
         endcase
         normal_queue.push_back(n);
      end
   endtask

   // Driver: hold a stalled item, otherwise advance or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (normal_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_data <= normal_queue[0];
            basis_queue.push_back(tangent_basis(normal_queue[0]));
            void'(normal_queue.pop_front());
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall and result checking
   always @(posedge clock) begin
      ftb_pkg::rsp_type want;
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_idle_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (basis_queue.size() == 0) begin
            $error("unexpected item %h", rsp_data);
            error_count++;
         end else begin
            want = basis_queue.pop_front();
            basis_checked++;
            if (rsp_data.degenerate) degenerate_seen++;
            if (rsp_data.tan1_x !== want.tan1_x) begin
               $error("tan1_x exp %0d got %0d", want.tan1_x, rsp_data.tan1_x);
               error_count++;
            end
            if (rsp_data.tan1_y !== want.tan1_y) begin
               $error("tan1_y exp %0d got %0d", want.tan1_y, rsp_data.tan1_y);
               error_count++;
            end
            if (rsp_data.tan1_z !== want.tan1_z) begin
               $error("tan1_z exp %0d got %0d", want.tan1_z, rsp_data.tan1_z);
               error_count++;
            end
            if (rsp_data.tan2_x !== want.tan2_x) begin
               $error("tan2_x exp %0d got %0d", want.tan2_x, rsp_data.tan2_x);
               error_count++;
            end
            if (rsp_data.tan2_y !== want.tan2_y) begin
               $error("tan2_y exp %0d got %0d", want.tan2_y, rsp_data.tan2_y);
               error_count++;
            end
            if (rsp_data.tan2_z !== want.tan2_z) begin
               $error("tan2_z exp %0d got %0d", want.tan2_z, rsp_data.tan2_z);
               error_count++;
            end
            if (rsp_data.degenerate !== want.degenerate) begin
               $error("degenerate exp %0b got %0b", want.degenerate, rsp_data.degenerate);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: zero normal, extremes, unit values, each pick
      queue_normal(0, 0, 0);
      queue_normal(UNIT_ONE, 0, 0);
      queue_normal(0, UNIT_ONE, 0);
      queue_normal(0, 0, UNIT_ONE);
      queue_normal(-UNIT_ONE, 0, 0);
      queue_normal(0, -UNIT_ONE, 0);
      queue_normal(0, 0, -UNIT_ONE);
      queue_normal(VALUE_MIN, 0, 0);
      queue_normal(0, VALUE_MIN, 0);
      queue_normal(0, 0, VALUE_MIN);
      queue_normal(VALUE_MIN, VALUE_MIN, VALUE_MIN);
      queue_normal(VALUE_MAX, VALUE_MAX, VALUE_MAX);
      queue_normal(VALUE_MAX, VALUE_MIN, VALUE_MAX);
      queue_normal(1, 0, 0);
      queue_normal(0, 1, -1);
      queue_normal(0, 0, 1);
      queue_normal(-1, -1, -1);
      queue_normal(0, VALUE_MAX, VALUE_MIN);
      queue_normal(UNIT_ONE, UNIT_ONE, UNIT_ONE);
      queue_normal(0, 0, VALUE_MAX);

      send_idle_pct = 18; recv_idle_pct = 58;
      queue_random(230);
      wait (normal_queue.size() == 0);
      send_idle_pct = 58; recv_idle_pct = 18;
      queue_random(230);
      wait (normal_queue.size() == 0);
      send_idle_pct = 0; recv_idle_pct = 0;
      queue_random(230);
      wait (normal_queue.size() == 0);
      @(posedge clock);
      wait (basis_queue.size() == 0);
      repeat (100) @(posedge clock);

      $display("Checked %0d tangent bases (%0d degenerate) over three idle patterns.",
               basis_checked, degenerate_seen);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2ms;
      $display("Timeout with %0d items outstanding", basis_queue.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
